/* hdl/hpsm_pkg.sv */
`timescale 1ns / 1ps

package hpsm_pkg;

  localparam int DEFAULT_COUNT_WIDTH = 32;
  localparam int FIELD_W             = 32;
  localparam int IVL_W               = 33;
  localparam int DIVIDEND_W          = FIELD_W;
  localparam int DIVISOR_W           = IVL_W;
  localparam int CFG_INDEX_W         = 2;

  localparam logic [FIELD_W-1:0] MIN_INTERVAL_RESET  = FIELD_W'(500);
  localparam logic [FIELD_W-1:0] RPM_NUMERATOR_RESET = FIELD_W'(540000000);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COUNTER_MAX   = 2'd0,
    REG_MIN_INTERVAL  = 2'd1,
    REG_RPM_NUMERATOR = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/hpsm_div.sv */
`timescale 1ns / 1ps

module hpsm_div
  import hpsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  div_ctl_t              ctl,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output div_stat_t             stat,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      count;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] quot;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // one restoring step per cycle while busy
  always_comb begin
    trial    = {rem, quot[DIVIDEND_W-1]};
    diff     = trial - {1'b0, dvs};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (ctl.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= '0;
    end else if (busy) begin
      count <= count + CNT_W'(1);
      if (count == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[DIVIDEND_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quot;

endmodule

/* hdl/hall_period_speed_meter_top.sv */
`timescale 1ns / 1ps
// channel   signals                          width
// -------   ------------------------------   -------------------------
// in        in_valid/in_ready, edge_count    32
// out       out_valid/out_ready, speed_rpm,  32
//           interval_ticks, speed_updated    33, 1
// cfg       cfg_we, cfg_index, cfg_data      1, 2, 32
//
// a request passes ST_LOAD and ST_CHECK, then ST_DIV for the 32 steps of the divider
// when the speed is recomputed, then ST_DONE; a rejected edge skips ST_DIV
// one request is in work at a time; in_ready drops until the result reaches
// the output register, which may still hold an untaken result meanwhile
// synchronous reset restores register defaults, previous count and speed to 0
// a stalled output holds the sequencer in its final state

module hall_period_speed_meter_top
  import hpsm_pkg::*;
#(
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FIELD_W-1:0]     edge_count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FIELD_W-1:0]     speed_rpm,
  output logic [IVL_W-1:0]       interval_ticks,
  output logic                   speed_updated,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]     cfg_data
);

  state_t state;
  state_t state_next;

  logic [COUNT_WIDTH-1:0] counter_max;
  logic [FIELD_W-1:0]     min_interval;
  logic [FIELD_W-1:0]     rpm_numerator;

  logic [COUNT_WIDTH-1:0] cur_count;
  logic [COUNT_WIDTH-1:0] previous_count;
  logic [FIELD_W-1:0]     held_speed;
  logic [IVL_W-1:0]       interval;
  logic [IVL_W-1:0]       interval_next;
  logic                   upd;

  logic                   in_take;
  logic                   load_ivl;
  logic                   check_ivl;
  logic                   out_load;

  div_ctl_t               div_ctl;
  div_stat_t              div_stat;
  logic [DIVIDEND_W-1:0]  quotient;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_max   <= {COUNT_WIDTH{1'b1}};
      min_interval  <= MIN_INTERVAL_RESET;
      rpm_numerator <= RPM_NUMERATOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNTER_MAX:   counter_max   <= cfg_data[COUNT_WIDTH-1:0];
        REG_MIN_INTERVAL:  min_interval  <= cfg_data;
        REG_RPM_NUMERATOR: rpm_numerator <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_CHECK;
      ST_CHECK: state_next = (interval > IVL_W'(min_interval)) ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_stat.done) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    load_ivl      = 1'b0;
    check_ivl     = 1'b0;
    div_ctl.start = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_LOAD:  load_ivl = 1'b1;
      ST_CHECK: begin
        check_ivl     = 1'b1;
        div_ctl.start = interval > IVL_W'(min_interval);
      end
      ST_DIV:   ;
      ST_DONE:  out_load = !out_valid || out_ready;
      default:  ;
    endcase
  end

  assign in_take = in_valid && in_ready;

  // interval with one timer wrap
  always_comb begin
    if (cur_count >= previous_count) begin
      interval_next = IVL_W'(cur_count) - IVL_W'(previous_count);
    end else begin
      interval_next = IVL_W'(counter_max) - IVL_W'(previous_count)
                    + IVL_W'(cur_count) + IVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_count <= edge_count[COUNT_WIDTH-1:0];
    end
    if (load_ivl) begin
      interval <= interval_next;
    end
    if (check_ivl) begin
      upd <= interval > IVL_W'(min_interval);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_count <= '0;
      held_speed     <= '0;
    end else begin
      if (load_ivl) begin
        previous_count <= cur_count;
      end
      if (state == ST_DIV && div_stat.done) begin
        held_speed <= quotient;
      end
    end
  end

  hpsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (rpm_numerator),
    .divisor  (interval),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      speed_rpm      <= held_speed;
      interval_ticks <= interval;
      speed_updated  <= upd;
    end
  end

  a_done_in_div : assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV || state == ST_DONE))
    else $error("divider finished outside the divide phase");

  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_out_drain : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && state != ST_DONE) |=> !out_valid)
    else $error("result shown again after it was taken");

endmodule

/* bench/tb_hall_period_speed_meter_top.sv */
`timescale 1ns / 1ps

module tb_hall_period_speed_meter_top;
  import hpsm_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int SEGMENT_EDGES = 154;
  localparam int SEGMENTS      = 4;

  typedef struct packed {
    logic [FIELD_W-1:0] speed;
    logic [IVL_W-1:0]   ticks;
    logic               updated;
  } speed_reading_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [FIELD_W-1:0]     edge_count;
  logic                   out_valid;
  logic                   out_ready;
  logic [FIELD_W-1:0]     speed_rpm;
  logic [IVL_W-1:0]       interval_ticks;
  logic                   speed_updated;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]     cfg_data;

  // predictor copy of registers and state
  logic [FIELD_W-1:0] counter_max   = '1;
  logic [FIELD_W-1:0] min_interval  = MIN_INTERVAL_RESET;
  logic [FIELD_W-1:0] rpm_numerator = RPM_NUMERATOR_RESET;
  logic [FIELD_W-1:0] prev_count    = '0;
  logic [FIELD_W-1:0] held_speed    = '0;

  speed_reading_t readings_due[$];
  int error_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;

  hall_period_speed_meter_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .edge_count     (edge_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .speed_rpm      (speed_rpm),
    .interval_ticks (interval_ticks),
    .speed_updated  (speed_updated),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic speed_reading_t measure_edge(input logic [FIELD_W-1:0] cur);
    speed_reading_t r;
    logic [63:0] quotient;
    if (cur >= prev_count) begin
      r.ticks = {1'b0, cur} - {1'b0, prev_count};
    end else begin
      r.ticks = {1'b0, counter_max} - {1'b0, prev_count} + {1'b0, cur} + 33'd1;
    end
    prev_count = cur;
    r.updated = r.ticks > {1'b0, min_interval};
    if (r.updated) begin
      quotient = {32'd0, rpm_numerator} / {31'd0, r.ticks};
      held_speed = quotient[FIELD_W-1:0];
    end
    r.speed = held_speed;
    return r;
  endfunction

  function automatic int pick_gap();
    int gap;
    gap = 0;
    if (send_idle_pct == 0) return 0;
    if ($urandom_range(99) < 10) return $urandom_range(45);
    while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    return gap;
  endfunction

  function automatic longint unsigned below(input longint unsigned n);
    longint unsigned x;
    x = {$urandom, $urandom};
    return x % n;
  endfunction

  // mostly timer-like captures stepped modulo the timer span, some noise
  function automatic logic [FIELD_W-1:0] next_capture();
    longint unsigned span;
    longint unsigned step;
    int pick;
    span = 64'(counter_max) + 64'd1;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom;
    if (pick < 16) return prev_count + 32'($urandom_range(2)) - 32'd1;
    case ($urandom_range(3))
      0: step = below(64'(min_interval) + 64'd1);
      1: step = 64'(min_interval) + 64'($urandom_range(1));
      2: step = 64'(min_interval) + 64'd1 + 64'($urandom_range(4000));
      default: step = below(span);
    endcase
    return 32'((64'(prev_count) + step) % span);
  endfunction

  task automatic send_edge(input logic [FIELD_W-1:0] value);
    int gap;
    gap = pick_gap();
    repeat (gap + 1) @(negedge clk);
    in_valid <= 1'b1;
    edge_count <= value;
    do @(posedge clk); while (!in_ready);
    readings_due.push_back(measure_edge(value));
    @(negedge clk);
    in_valid <= 1'b0;
    edge_count <= $urandom;
  endtask

  task automatic wait_idle();
    while (readings_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [FIELD_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COUNTER_MAX:   counter_max = value;
      REG_MIN_INTERVAL:  min_interval = value;
      REG_RPM_NUMERATOR: rpm_numerator = value;
      default: ;
    endcase
  endtask

  task automatic configure_random();
    logic [FIELD_W-1:0] top;
    logic [FIELD_W-1:0] floor_ticks;
    logic [FIELD_W-1:0] numerator;
    case ($urandom_range(4))
      0: top = '1;
      1: top = $urandom_range(32'hFFFF_FFFF, 1);
      2: top = (32'd1 << $urandom_range(31, 4)) - 32'd1;
      3: top = $urandom_range(5000, 1);
      default: top = 32'd1;
    endcase
    case ($urandom_range(5))
      0: floor_ticks = '0;
      1: floor_ticks = $urandom_range(2000);
      2: floor_ticks = MIN_INTERVAL_RESET;
      3: floor_ticks = $urandom;
      4: floor_ticks = $urandom_range(40);
      default: floor_ticks = ($urandom_range(3) == 0) ? '1 : 32'($urandom_range(600));
    endcase
    case ($urandom_range(3))
      0: numerator = 32'd1;
      1: numerator = '1;
      2: numerator = RPM_NUMERATOR_RESET;
      default: numerator = $urandom_range(32'hFFFF_FFFF, 1);
    endcase
    write_register(REG_COUNTER_MAX, top);
    write_register(REG_MIN_INTERVAL, floor_ticks);
    write_register(REG_RPM_NUMERATOR, numerator);
  endtask

  // reset settings: first edge against zero, equal counts, threshold, wraps
  task automatic test_first_edges();
    send_edge(32'd0);
    send_edge(32'd1000);
    send_edge(32'd1500);
    send_edge(32'd2001);
    send_edge(32'hFFFF_FFFF);
    send_edge(32'h0000_0010);
    send_edge(32'h8000_0000);
    send_edge(32'h7FFF_FFFF);
  endtask

  // register extremes and a previous count above the timer top
  task automatic test_register_extremes();
    wait_idle();
    write_register(REG_COUNTER_MAX, 32'd1000);
    write_register(REG_MIN_INTERVAL, 32'd0);
    write_register(REG_RPM_NUMERATOR, 32'hFFFF_FFFF);
    send_edge(32'd10);
    send_edge(32'd11);
    send_edge(32'd5);
    send_edge(32'd5000);
    send_edge(32'd3);
    wait_idle();
    write_register(REG_COUNTER_MAX, 32'd1);
    write_register(REG_MIN_INTERVAL, 32'hFFFF_FFFF);
    write_register(REG_RPM_NUMERATOR, 32'd1);
    send_edge(32'd0);
    send_edge(32'd1);
    send_edge(32'd0);
    send_edge(32'hFFFF_FFFF);
    send_edge(32'd0);
    send_edge(32'd1);
    wait_idle();
    write_register(REG_COUNTER_MAX, 32'hFFFF_FFFF);
    write_register(REG_MIN_INTERVAL, MIN_INTERVAL_RESET);
    write_register(REG_RPM_NUMERATOR, RPM_NUMERATOR_RESET);
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (SEGMENTS) begin
      wait_idle();
      configure_random();
      repeat (SEGMENT_EDGES) send_edge(next_capture());
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (recv_idle_pct > 0 && $urandom_range(99) < 2) begin
      stall_left = $urandom_range(60);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    speed_reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        error_count++;
        $display("%0t unexpected result: expected none actual speed %0d ticks %0d flag %0b",
                 $time, speed_rpm, interval_ticks, speed_updated);
      end else begin
        want = readings_due.pop_front();
        if (speed_rpm !== want.speed) begin
          error_count++;
          $display("%0t speed_rpm expected %0d actual %0d", $time, want.speed, speed_rpm);
        end
        if (interval_ticks !== want.ticks) begin
          error_count++;
          $display("%0t interval_ticks expected %0d actual %0d",
                   $time, want.ticks, interval_ticks);
        end
        if (speed_updated !== want.updated) begin
          error_count++;
          $display("%0t speed_updated expected %0b actual %0b",
                   $time, want.updated, speed_updated);
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_hall_period_speed_meter_top: errors");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    edge_count = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_COUNTER_MAX;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 52;
    test_first_edges();
    test_register_extremes();
    test_random_traffic(29, 52);
    test_random_traffic(52, 29);
    test_random_traffic(0, 0);
    while (readings_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && readings_due.size() == 0) begin
      $display("tb_hall_period_speed_meter_top: clean");
    end else begin
      $display("tb_hall_period_speed_meter_top: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/hpsm_pkg.sv
hdl/hpsm_div.sv
hdl/hall_period_speed_meter_top.sv
bench/tb_hall_period_speed_meter_top.sv
